### src/thermistor_probe_monitor_unit_defines.svh
// Assertion macros for the thermistor probe monitor.
// Used by the top level only; relies on clk and arst_n in the including scope.
`ifndef THERMISTOR_PROBE_MONITOR_UNIT_DEFINES_SVH
`define THERMISTOR_PROBE_MONITOR_UNIT_DEFINES_SVH

// Implication checked in the same cycle, masked while reset is asserted.
`define TPM_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Invariant checked at every clock edge, masked while reset is asserted.
`define TPM_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

`endif

### src/tpm_pkg.sv
// Shared types, constants and conversion functions of the thermistor probe monitor.
// No dependencies; imported by every module of the block.
package tpm_pkg;

	// Field widths fixed by the word formats.
	localparam int PROBE_W = 2;
	localparam int TEMP_W = 15;
	localparam int TOTAL_W = 3;
	localparam int TUSER_W = 4;
	localparam int OUT_TDATA_W = ((PROBE_W + TEMP_W + TOTAL_W + 7) / 8) * 8;

	// Default configuration of the block.
	localparam int DEF_PROBE_SLOTS = 4;
	localparam int DEF_ADC_WIDTH = 10;
	localparam int QUEUE_DEPTH = 2;

	// Temperature limits in 1/16 degree Fahrenheit.
	localparam int TEMP_MIN = -8192;
	localparam int TEMP_MAX = 16383;
	localparam int TEMP_CODE_ONE = -7350;

	// How the front end classifies a sample.
	typedef enum logic [1:0] {
		KIND_READING = 2'd0,
		KIND_ABSENT  = 2'd1,
		KIND_NO_SLOT = 2'd2
	} kind_t;

	// One classified word handed from the front end to the back end.
	typedef struct packed {
		logic [PROBE_W-1:0] idx;
		kind_t kind;
		logic signed [TEMP_W-1:0] temp;
	} entry_t;

	// One result word.
	typedef struct packed {
		logic [TOTAL_W-1:0] connected_total;
		logic change_event;
		logic disconnect_event;
		logic connect_event;
		logic is_connected;
		logic signed [TEMP_W-1:0] temperature;
		logic [PROBE_W-1:0] probe_echo;
	} result_t;

	// Base-2 logarithm of an integer in Q28. The integer part comes from the
	// leading one, the fraction from repeated squaring of a Q30 mantissa.
	function automatic logic [63:0] lg_q28(input logic [31:0] n);
		logic [5:0] k;
		logic [63:0] m;
		logic [63:0] frac;
		k = '0;
		frac = '0;
		if (n == 32'd0) begin
			return 64'd0;
		end
		for (int i = 0; i <= 30; i++) begin
			if (n[i]) begin
				k = 6'(i);
			end
		end
		m = ({32'd0, n} << (6'd30 - k)) & 64'h0000_0000_FFFF_FFFF;
		for (int i = 0; i < 28; i++) begin
			m = (m * m) >> 30;
			frac = frac << 1;
			if (m >= 64'h0000_0000_8000_0000) begin
				frac = frac | 64'd1;
				m = m >> 1;
			end
		end
		return ({58'd0, k} << 28) | frac;
	endfunction

	// Converter code to temperature through the Steinhart-Hart relation of a
	// thermistor in a 10 kOhm divider. Evaluated only while the lookup table
	// is built; the final quotient uses a shift-subtract long division.
	function automatic logic signed [TEMP_W-1:0] code_to_temp(input logic [31:0] x,
			input logic [31:0] span);
		logic signed [63:0] g;
		logic [63:0] l;
		logic [63:0] l2;
		logic [63:0] l3;
		logic [63:0] s;
		logic [63:0] dd;
		logic signed [63:0] num;
		logic [63:0] mag;
		logic [63:0] den;
		logic [63:0] q;
		logic [63:0] r;
		logic signed [63:0] qs;
		if (x == 32'd1) begin
			return TEMP_W'(TEMP_CODE_ONE);
		end
		g = signed'(lg_q28(32'd10000)) + signed'(lg_q28(x - 32'd1))
			- signed'(lg_q28(span - x));
		if (g < 0) begin
			g = '0;
		end
		// Natural log of the resistance in Q24, then its square and cube.
		l = (unsigned'(g) * 64'd744261118) >> 34;
		l2 = (l * l) >> 24;
		l3 = (l2 * l) >> 32;
		s = (64'd7343140544 << 24) + 64'd2157437229 * l
			+ (64'd951568577 * l3) / 64'd39062500;
		dd = s >> 14;
		if (dd == 64'd0) begin
			dd = 64'd1;
		end
		// The numerator goes negative for readings below zero degrees.
		num = 64'sd2949120000000000000 - 64'sd73499 * signed'(dd);
		den = 64'd10 * dd;
		mag = (num < 0) ? unsigned'(-num) : unsigned'(num);
		q = '0;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[62:0], mag[i]};
			if (r >= den) begin
				r = r - den;
				q[i] = 1'b1;
			end
		end
		// Round the quotient toward minus infinity.
		if (num < 0) begin
			qs = -signed'(q);
			if (r != 64'd0) begin
				qs = qs - 64'sd1;
			end
		end else begin
			qs = signed'(q);
		end
		if (qs < 64'(TEMP_MIN)) begin
			return TEMP_W'(TEMP_MIN);
		end
		if (qs > 64'(TEMP_MAX)) begin
			return TEMP_W'(TEMP_MAX);
		end
		return TEMP_W'(qs);
	endfunction

endpackage

### src/thermistor_probe_monitor_unit.sv
// Thermistor probe monitor: takes one converter sample word per cycle while
// s_axis_tready is high and returns one result word per sample. The front end
// classifies each sample and reads its temperature from a conversion ROM (one
// read port, registered), a two-word queue decouples it from the back end,
// which updates the per-probe state and holds the result in an output register.
// A word passes the front-end stage register, the queue and the output register.
// Sustained throughput is one word per cycle while m_axis_tready stays high,
// set by the single ROM read port and the single state update per cycle. The
// ROM holds 2**ADC_WIDTH entries and is filled at elaboration, so there is no
// fill time after reset. Codes 0 and full scale mark a probe as absent.
// Depends on tpm_pkg, tpm_front, tpm_queue, tpm_back and the defines header.
`include "thermistor_probe_monitor_unit_defines.svh"

module thermistor_probe_monitor_unit #(
	parameter int PROBE_SLOTS = tpm_pkg::DEF_PROBE_SLOTS,
	parameter int ADC_WIDTH = tpm_pkg::DEF_ADC_WIDTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// probe_index, adc_sample, zero fill (lowest bit first)
	input  logic [((tpm_pkg::PROBE_W + ADC_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// probe_echo, temperature, connected_total, zero fill (lowest bit first)
	output logic [tpm_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	// is_connected, connect_event, disconnect_event, change_event (lowest bit first)
	output logic [tpm_pkg::TUSER_W-1:0] m_axis_tuser
);
	import tpm_pkg::*;

	localparam int CNT_RAW_W = $clog2(PROBE_SLOTS + 1);
	localparam int CNT_W = (CNT_RAW_W > TOTAL_W) ? CNT_RAW_W : TOTAL_W;
	localparam int PAYLOAD_W = PROBE_W + TEMP_W + TOTAL_W;

	logic push;
	logic pop;
	logic q_empty;
	logic q_full;
	entry_t push_entry;
	entry_t head;
	result_t result;
	logic [PROBE_SLOTS-1:0] link_flags;
	logic [CNT_W-1:0] link_count;

	tpm_front #(
		.PROBE_SLOTS(PROBE_SLOTS),
		.ADC_WIDTH(ADC_WIDTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.probe_index(s_axis_tdata[PROBE_W-1:0]),
		.adc_sample(s_axis_tdata[PROBE_W+ADC_WIDTH-1:PROBE_W]),
		.queue_full(q_full),
		.push(push),
		.entry(push_entry)
	);

	tpm_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_entry(push_entry),
		.pop(pop),
		.head(head),
		.empty(q_empty),
		.full(q_full)
	);

	tpm_back #(
		.PROBE_SLOTS(PROBE_SLOTS),
		.CNT_W(CNT_W)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.queue_empty(q_empty),
		.pop(pop),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.result(result),
		.link_flags(link_flags),
		.link_count(link_count)
	);

	// Pack the result word onto the output stream.
	assign m_axis_tdata = {{(OUT_TDATA_W - PAYLOAD_W){1'b0}}, result.connected_total,
		result.temperature, result.probe_echo};
	assign m_axis_tuser = {result.change_event, result.disconnect_event,
		result.connect_event, result.is_connected};

	// A disconnect reports a cleared temperature and a probe no longer connected.
	`TPM_ASSERT_IMPLY(a_disconnect_clears, m_axis_tvalid && result.disconnect_event, result.temperature == '0 && !result.is_connected, "disconnect word carries a temperature or a connected flag")

	// A connect event only comes with a connected probe and never with a disconnect.
	`TPM_ASSERT_IMPLY(a_connect_consistent, m_axis_tvalid && result.connect_event, result.is_connected && !result.disconnect_event, "connect event without a connected probe")

	// The connected count always matches the per-probe flags.
	`TPM_ASSERT_ALWAYS(a_count_matches_flags, $countones(link_flags) == int'(link_count), "connected count disagrees with the probe flags")

endmodule

### src/tpm_front.sv
// Front end of the thermistor probe monitor: accepts sample words, classifies
// them and looks the temperature up in the conversion ROM. Depends on tpm_pkg.
module tpm_front #(
	parameter int PROBE_SLOTS = tpm_pkg::DEF_PROBE_SLOTS,
	parameter int ADC_WIDTH = tpm_pkg::DEF_ADC_WIDTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [tpm_pkg::PROBE_W-1:0] probe_index,
	input  logic [ADC_WIDTH-1:0] adc_sample,
	input  logic queue_full,
	output logic push,
	output tpm_pkg::entry_t entry
);
	import tpm_pkg::*;

	localparam int ROM_DEPTH = 2 ** ADC_WIDTH;

	typedef logic signed [TEMP_W-1:0] rom_t [ROM_DEPTH];

	// Conversion table, one entry per converter code; the absent codes hold zero.
	function automatic rom_t build_rom();
		rom_t rom;
		for (int c = 0; c < ROM_DEPTH; c++) begin
			if (c == 0 || c == ROM_DEPTH - 1) begin
				rom[c] = '0;
			end else begin
				rom[c] = code_to_temp(32'(c), 32'(ROM_DEPTH));
			end
		end
		return rom;
	endfunction

	localparam rom_t TEMP_ROM = build_rom();

	logic valid_s1;
	logic [PROBE_W-1:0] idx_s1;
	kind_t kind_s1;
	logic signed [TEMP_W-1:0] temp_s1;
	kind_t kind_in;
	logic accept;

	// Classify the incoming word.
	always_comb begin
		if (int'(probe_index) >= PROBE_SLOTS) begin
			kind_in = KIND_NO_SLOT;
		end else if (adc_sample == '0 || adc_sample == '1) begin
			kind_in = KIND_ABSENT;
		end else begin
			kind_in = KIND_READING;
		end
	end

	// The stage empties into the queue whenever the queue has room.
	assign push = valid_s1 && !queue_full;
	assign in_ready = !valid_s1 || !queue_full;
	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	// ROM read and classification results, registered together.
	always_ff @(posedge clk) begin
		if (accept) begin
			idx_s1 <= probe_index;
			kind_s1 <= kind_in;
			temp_s1 <= TEMP_ROM[adc_sample];
		end
	end

	assign entry = '{idx: idx_s1, kind: kind_s1, temp: temp_s1};

endmodule

### src/tpm_queue.sv
// Short queue of classified words between the front end and the back end.
// Depends on tpm_pkg for the word type.
module tpm_queue #(
	parameter int DEPTH = tpm_pkg::QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  tpm_pkg::entry_t push_entry,
	input  logic pop,
	output tpm_pkg::entry_t head,
	output logic empty,
	output logic full
);
	import tpm_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	entry_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign empty = (count_q == '0);
	assign full = (count_q == CNT_W'(DEPTH));
	assign head = mem_q[rd_ptr_q];

	// Storage is written only on a push.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers wrap at the depth; the count tracks occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### src/tpm_back.sv
// Back end of the thermistor probe monitor: applies each classified word to
// the per-probe state and registers the result word. Depends on tpm_pkg.
module tpm_back #(
	parameter int PROBE_SLOTS = tpm_pkg::DEF_PROBE_SLOTS,
	parameter int CNT_W = 3
) (
	input  logic clk,
	input  logic arst_n,
	input  tpm_pkg::entry_t head,
	input  logic queue_empty,
	output logic pop,
	output logic out_valid,
	input  logic out_ready,
	output tpm_pkg::result_t result,
	output logic [PROBE_SLOTS-1:0] link_flags,
	output logic [CNT_W-1:0] link_count
);
	import tpm_pkg::*;

	logic [PROBE_SLOTS-1:0] flags_q;
	logic signed [TEMP_W-1:0] temps_q [PROBE_SLOTS];
	logic [CNT_W-1:0] count_q;
	logic out_valid_q;
	result_t res_q;

	logic [PROBE_SLOTS-1:0] sel;
	logic was;
	logic signed [TEMP_W-1:0] old_temp;
	logic upd;
	logic new_flag;
	logic signed [TEMP_W-1:0] new_temp;
	logic [CNT_W-1:0] count_next;
	result_t res_next;

	// Take the next word whenever the output register is free or draining.
	assign pop = !queue_empty && (!out_valid_q || out_ready);

	// Select the addressed probe's stored state.
	always_comb begin
		was = 1'b0;
		old_temp = '0;
		for (int i = 0; i < PROBE_SLOTS; i++) begin
			sel[i] = (int'(head.idx) == i);
			if (sel[i]) begin
				was = flags_q[i];
				old_temp = temps_q[i];
			end
		end
	end

	// Work out the new state and the result word.
	always_comb begin
		upd = 1'b0;
		new_flag = 1'b0;
		new_temp = '0;
		count_next = count_q;
		res_next = '0;
		res_next.probe_echo = head.idx;
		case (head.kind)
			KIND_READING: begin
				upd = 1'b1;
				new_flag = 1'b1;
				new_temp = head.temp;
				if (!was) begin
					count_next = count_q + 1'b1;
				end
				res_next.temperature = head.temp;
				res_next.is_connected = 1'b1;
				res_next.connect_event = !was;
				res_next.change_event = (head.temp != old_temp);
			end
			KIND_ABSENT: begin
				upd = 1'b1;
				if (was) begin
					count_next = count_q - 1'b1;
				end
				res_next.disconnect_event = was;
			end
			default: begin
				upd = 1'b0;
			end
		endcase
		res_next.connected_total = count_next[TOTAL_W-1:0];
	end

	// Per-probe state, cleared by reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
			count_q <= '0;
			for (int i = 0; i < PROBE_SLOTS; i++) begin
				temps_q[i] <= '0;
			end
		end else if (pop && upd) begin
			count_q <= count_next;
			for (int i = 0; i < PROBE_SLOTS; i++) begin
				if (sel[i]) begin
					flags_q[i] <= new_flag;
					temps_q[i] <= new_temp;
				end
			end
		end
	end

	// Output register holds the word until the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res_next;
		end
	end

	assign out_valid = out_valid_q;
	assign result = res_q;
	assign link_flags = flags_q;
	assign link_count = count_q;

endmodule
